// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/kdpc_pkg.sv =====
// Types and constants for the key debounce / press classifier.
// No dependencies.
package kdpc_pkg;

  localparam int PIN_W   = 6;
  localparam int KEY_W   = 3;
  localparam int CODE_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 16;

  localparam logic [CODE_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [CODE_W-1:0] EV_RELEASE = 2'd1;
  localparam logic [CODE_W-1:0] EV_SHORT   = 2'd2;
  localparam logic [CODE_W-1:0] EV_LONG    = 2'd3;

  localparam logic [CIDX_W-1:0] REG_SCAN     = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 3'd1;
  localparam logic [CIDX_W-1:0] REG_SHORT    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_LONG     = 3'd3;
  localparam logic [CIDX_W-1:0] REG_PRESSED  = 3'd4;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DEB    = 6'b000010,
    ST_SHORT1 = 6'b000100,
    ST_SHORT2 = 6'b001000,
    ST_HOLD   = 6'b010000,
    ST_FLUSH  = 6'b100000
  } state_t;

endpackage

// ===== src/key_debounce_press_classifier_core.sv =====
// Key debounce and press classifier, top level.
// Depends on kdpc_pkg.
//
// Usage:
//   in_*  : one beat per scan tick, in_pin_levels bit i = raw level of key i.
//   out_* : event beats (key, code, last); out_last_event marks the final
//           event caused by a tick. A tick that causes no event sends nothing.
//   cfg_* : register writes, always ready; write only while the block is idle.
// Timing:
//   A tick is walked key by key through one shared saturating add/compare
//   unit: after the accept step each key passes ST_DEB and then ST_HOLD,
//   with ST_SHORT1 and ST_SHORT2 between for a release; ST_FLUSH ends it.
//   in_stall stays high from accept until the walk ends.
//   Events go through a one-deep pending register into the output register;
//   the pending one is sent once the next event (or the end of tick) is known.
//   A stalled output holds its beat and stalls the walk only when a new event
//   must be emitted while one is pending, or at the flush with one pending.
// Reset (synchronous, rst_n low): registers take their defaults, every key
//   reads stably not pressed, counters clear, no beat is pending.
module key_debounce_press_classifier_core
  import kdpc_pkg::*;
#(
  parameter int NUM_KEYS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIN_W-1:0]   in_pin_levels,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KEY_W-1:0]   out_key_index,
  output logic [CODE_W-1:0]  out_event_code,
  output logic               out_last_event,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data
);

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  state_t              state_r, state_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [PIN_W-1:0]    pins_r, pins_nxt;
  logic [NUM_KEYS-1:0] stable_r, stable_nxt;
  logic [NUM_KEYS-1:0] lr_r, lr_nxt;
  logic [7:0]          dcnt_r [NUM_KEYS];
  logic [7:0]          dcnt_nxt [NUM_KEYS];
  logic [15:0]         hold_r [NUM_KEYS];
  logic [15:0]         hold_nxt [NUM_KEYS];
  logic                short_ok_r, short_ok_nxt;

  logic                pend_v_r, pend_v_nxt;
  logic [KW-1:0]       pend_key_r, pend_key_nxt;
  logic [CODE_W-1:0]   pend_code_r, pend_code_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [CODE_W-1:0]   out_code_r, out_code_nxt;
  logic                out_last_r, out_last_nxt;

  logic [7:0]          scan_r, scan_nxt;
  logic [7:0]          deb_r, deb_nxt;
  logic [15:0]         short_r, short_nxt;
  logic [15:0]         long_r, long_nxt;
  logic                pressed_r, pressed_nxt;

  logic [NUM_KEYS-1:0] lvl_vec;
  logic                lvl;
  logic [15:0]         u_a, u_c, u_sum;
  logic [7:0]          u_b;
  logic                u_narrow, u_ge;
  logic                emit_req, go, out_free;
  logic [CODE_W-1:0]   emit_code;

  // keys past the pin field read level 0
  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lvl
    if (g < PIN_W) begin : g_pin
      assign lvl_vec[g] = pins_r[g];
    end else begin : g_zero
      assign lvl_vec[g] = 1'b0;
    end
  end

  assign lvl = lvl_vec[key_r];

  // shared saturating adder and compare
  always_comb begin
    logic [16:0] s;
    logic [16:0] lim;
    s     = {1'b0, u_a} + {9'b0, u_b};
    lim   = u_narrow ? 17'h000FF : 17'h0FFFF;
    u_sum = (s > lim) ? lim[15:0] : s[15:0];
    u_ge  = (u_sum >= u_c);
  end

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    pins_nxt      = pins_r;
    stable_nxt    = stable_r;
    lr_nxt        = lr_r;
    dcnt_nxt      = dcnt_r;
    hold_nxt      = hold_r;
    short_ok_nxt  = short_ok_r;
    pend_v_nxt    = pend_v_r;
    pend_key_nxt  = pend_key_r;
    pend_code_nxt = pend_code_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    scan_nxt      = scan_r;
    deb_nxt       = deb_r;
    short_nxt     = short_r;
    long_nxt      = long_r;
    pressed_nxt   = pressed_r;

    u_a       = hold_r[key_r];
    u_b       = 8'd0;
    u_c       = long_r;
    u_narrow  = 1'b0;
    emit_req  = 1'b0;
    emit_code = EV_PRESS;

    out_free = !out_valid_r || !out_stall;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // operand select per step
    unique case (state_r)
      ST_DEB: begin
        u_a      = {8'd0, dcnt_r[key_r]};
        u_b      = scan_r;
        u_c      = {8'd0, deb_r};
        u_narrow = 1'b1;
      end
      ST_SHORT1: begin
        u_c = short_r;
      end
      ST_HOLD: begin
        u_b = scan_r;
      end
      default: begin
      end
    endcase

    unique case (state_r)
      ST_DEB: begin
        if (lvl != stable_r[key_r] && u_ge) begin
          emit_req  = 1'b1;
          emit_code = (lvl == pressed_r) ? EV_PRESS : EV_RELEASE;
        end
      end
      ST_SHORT2: begin
        emit_req  = short_ok_r && !u_ge;
        emit_code = EV_SHORT;
      end
      ST_HOLD: begin
        emit_req  = (stable_r[key_r] == pressed_r) && !lr_r[key_r] && u_ge;
        emit_code = EV_LONG;
      end
      default: begin
      end
    endcase

    go = !emit_req || !pend_v_r || out_free;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pins_nxt  = in_pin_levels;
          key_nxt   = '0;
          state_nxt = ST_DEB;
        end
      end
      ST_DEB: begin
        if (lvl == stable_r[key_r]) begin
          dcnt_nxt[key_r] = 8'd0;
          state_nxt       = ST_HOLD;
        end else if (!u_ge) begin
          dcnt_nxt[key_r] = u_sum[7:0];
          state_nxt       = ST_HOLD;
        end else if (go) begin
          stable_nxt[key_r] = lvl;
          dcnt_nxt[key_r]   = 8'd0;
          if (lvl == pressed_r) begin
            hold_nxt[key_r] = 16'd0;
            lr_nxt[key_r]   = 1'b0;
            state_nxt       = ST_HOLD;
          end else begin
            state_nxt = ST_SHORT1;
          end
        end
      end
      ST_SHORT1: begin
        short_ok_nxt = u_ge;
        state_nxt    = ST_SHORT2;
      end
      ST_SHORT2: begin
        // u_ge here is hold >= long
        if (go) begin
          hold_nxt[key_r] = 16'd0;
          lr_nxt[key_r]   = 1'b0;
          state_nxt       = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (go) begin
          if (stable_r[key_r] == pressed_r) begin
            hold_nxt[key_r] = u_sum;
            if (emit_req) begin
              lr_nxt[key_r] = 1'b1;
            end
          end
          if (key_r == KW'(NUM_KEYS - 1)) begin
            state_nxt = ST_FLUSH;
          end else begin
            key_nxt   = key_r + 1'b1;
            state_nxt = ST_DEB;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = KEY_W'(pend_key_r);
          out_code_nxt  = pend_code_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // new event goes to pending; the older pending beat moves out
    if (emit_req && go) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = KEY_W'(pend_key_r);
        out_code_nxt  = pend_code_r;
        out_last_nxt  = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_key_nxt  = key_r;
      pend_code_nxt = emit_code;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCAN:     scan_nxt    = cfg_data[7:0];
        REG_DEBOUNCE: deb_nxt     = cfg_data[7:0];
        REG_SHORT:    short_nxt   = cfg_data;
        REG_LONG:     long_nxt    = cfg_data;
        REG_PRESSED:  pressed_nxt = cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      key_r       <= '0;
      stable_r    <= '1;
      lr_r        <= '0;
      short_ok_r  <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      scan_r      <= 8'd10;
      deb_r       <= 8'd20;
      short_r     <= 16'd50;
      long_r      <= 16'd1000;
      pressed_r   <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        dcnt_r[i] <= 8'd0;
        hold_r[i] <= 16'd0;
      end
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      stable_r    <= stable_nxt;
      lr_r        <= lr_nxt;
      short_ok_r  <= short_ok_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      scan_r      <= scan_nxt;
      deb_r       <= deb_nxt;
      short_r     <= short_nxt;
      long_r      <= long_nxt;
      pressed_r   <= pressed_nxt;
      dcnt_r      <= dcnt_nxt;
      hold_r      <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pins_r      <= pins_nxt;
    pend_key_r  <= pend_key_nxt;
    pend_code_r <= pend_code_nxt;
    out_key_r   <= out_key_nxt;
    out_code_r  <= out_code_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_key_index  = out_key_r;
  assign out_event_code = out_code_r;
  assign out_last_event = out_last_r;
  assign cfg_ready      = 1'b1;

endmodule

// ===== src/kdpc_checker.sv =====
// Port-level checker for the key debounce / press classifier, with its bind.
// Depends on kdpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kdpc_checker
  import kdpc_pkg::*;
#(
  parameter int NUM_KEYS = 6
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [KEY_W-1:0]   out_key_index,
  input logic [CODE_W-1:0]  out_event_code,
  input logic               out_last_event
);

  localparam bit KEY_FITS = (NUM_KEYS <= 8);

  // a stalled output beat holds
  `CHK_NEXT(a_out_hold, out_valid && out_stall,
            out_valid && $stable(out_key_index) && $stable(out_event_code)
            && $stable(out_last_event))

  // an accepted tick blocks the input while keys are walked
  `CHK_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // once idle, only the final beat of a tick can be left waiting
  `CHK_SAME(a_idle_last, out_valid && !in_stall, out_last_event)

  // events only name existing keys
  `CHK_SAME(a_key_range, out_valid && KEY_FITS, 32'(out_key_index) < NUM_KEYS)

endmodule

bind key_debounce_press_classifier_core kdpc_checker #(.NUM_KEYS(NUM_KEYS)) u_kdpc_checker (.*);

// ===== tb/kdpc_event_checker.sv =====
`timescale 1ns / 1ps
// Event checker for the key debounce / press classifier: follows register writes,
// predicts the events of each accepted scan tick and compares every event beat.
// Depends on kdpc_pkg.
module kdpc_event_checker
  import kdpc_pkg::*;
#(
  parameter int NUM_KEYS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [PIN_W-1:0]   in_pin_levels,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [KEY_W-1:0]   out_key_index,
  input  logic [CODE_W-1:0]  out_event_code,
  input  logic               out_last_event,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [CDATA_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 awaited
);

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CODE_W-1:0] code;
    logic              last;
  } key_event_t;

  key_event_t pending_events[$];

  logic [7:0]  scan_ms;
  logic [7:0]  debounce_ms;
  logic [15:0] short_ms;
  logic [15:0] long_ms;
  logic        pressed_lvl;

  logic        stable_lvl [NUM_KEYS];
  logic [7:0]  bounce_cnt [NUM_KEYS];
  logic [15:0] held_ms    [NUM_KEYS];
  logic        long_fired [NUM_KEYS];

  function automatic void push_event(int k, logic [CODE_W-1:0] code);
    key_event_t ev;
    ev.key  = KEY_W'(k);
    ev.code = code;
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  // One scan tick: walk the keys in index order, queue the events it causes.
  function automatic void classify_tick(logic [PIN_W-1:0] pins);
    int          first;
    logic        lvl;
    logic [8:0]  bounce_sum;
    logic [16:0] hold_sum;
    key_event_t  ev;
    first = pending_events.size();
    for (int k = 0; k < NUM_KEYS; k++) begin
      lvl = (k < PIN_W) ? pins[k] : 1'b0;
      if (lvl == stable_lvl[k]) begin
        bounce_cnt[k] = '0;
      end else begin
        bounce_sum    = bounce_cnt[k] + scan_ms;
        bounce_cnt[k] = bounce_sum[8] ? 8'hFF : bounce_sum[7:0];
        if (bounce_cnt[k] >= debounce_ms) begin
          stable_lvl[k] = lvl;
          bounce_cnt[k] = '0;
          if (lvl == pressed_lvl) begin
            held_ms[k]    = '0;
            long_fired[k] = 1'b0;
            push_event(k, EV_PRESS);
          end else begin
            push_event(k, EV_RELEASE);
            if (held_ms[k] < long_ms && held_ms[k] >= short_ms)
              push_event(k, EV_SHORT);
            held_ms[k]    = '0;
            long_fired[k] = 1'b0;
          end
        end
      end
      if (stable_lvl[k] == pressed_lvl) begin
        hold_sum   = held_ms[k] + scan_ms;
        held_ms[k] = hold_sum[16] ? 16'hFFFF : hold_sum[15:0];
        if (!long_fired[k] && held_ms[k] >= long_ms) begin
          long_fired[k] = 1'b1;
          push_event(k, EV_LONG);
        end
      end
    end
    // last flag goes on the final event of the tick
    if (pending_events.size() > first) begin
      ev = pending_events.pop_back();
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
  endfunction

  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      scan_ms     = 8'd10;
      debounce_ms = 8'd20;
      short_ms    = 16'd50;
      long_ms     = 16'd1000;
      pressed_lvl = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        stable_lvl[k] = ~pressed_lvl;
        bounce_cnt[k] = '0;
        held_ms[k]    = '0;
        long_fired[k] = 1'b0;
      end
      pending_events.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCAN:     scan_ms     = cfg_data[7:0];
          REG_DEBOUNCE: debounce_ms = cfg_data[7:0];
          REG_SHORT:    short_ms    = cfg_data[15:0];
          REG_LONG:     long_ms     = cfg_data[15:0];
          REG_PRESSED:  pressed_lvl = cfg_data[0];
          default: ;
        endcase
      end
      // compare before predicting: a beat can never belong to the tick accepted now
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          $error("event beat with nothing expected: key_index %0d event_code %0d last_event %0b",
                 out_key_index, out_event_code, out_last_event);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (out_key_index !== want.key) begin
            $error("key_index: expected %0d, got %0d", want.key, out_key_index);
            fail_count++;
          end
          if (out_event_code !== want.code) begin
            $error("event_code: expected %0d, got %0d", want.code, out_event_code);
            fail_count++;
          end
          if (out_last_event !== want.last) begin
            $error("last_event: expected %0b, got %0b", want.last, out_last_event);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        classify_tick(in_pin_levels);
    end
    awaited = pending_events.size();
  end

endmodule

// ===== tb/tb_key_debounce_press_classifier_core.sv =====
`timescale 1ns / 1ps
// Testbench top for key_debounce_press_classifier_core: scan ticks, register writes
// and output stalls; event prediction and checking sit in kdpc_event_checker.
// Depends on kdpc_pkg, kdpc_event_checker and the block's RTL.
module tb_key_debounce_press_classifier_core;
  import kdpc_pkg::*;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [PIN_W-1:0]   in_pin_levels = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [KEY_W-1:0]   out_key_index;
  logic [CODE_W-1:0]  out_event_code;
  logic               out_last_event;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CIDX_W-1:0]  cfg_index     = REG_SCAN;
  logic [CDATA_W-1:0] cfg_data      = '0;

  int fail_count;
  int awaited;

  logic             calm       = 1'b0;  // no idling on either side
  int               stall_left = 0;
  int               quiet_left = 0;
  logic [PIN_W-1:0] lane_level = '0;    // per-key level the random stream holds
  int               lane_run [PIN_W];

  always #2 clk = ~clk;

  key_debounce_press_classifier_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pin_levels  (in_pin_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_event_code (out_event_code),
    .out_last_event (out_last_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  kdpc_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pin_levels  (in_pin_levels),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_event_code (out_event_code),
    .out_last_event (out_last_event),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .awaited        (awaited)
  );

  // Receiver stalls: random bursts, with stall-free stretches between.
  always @(negedge clk) begin
    if (calm || quiet_left > 0) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      if (quiet_left > 0)
        quiet_left <= quiet_left - 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 49) == 0)
        quiet_left <= $urandom_range(20, 80);
    end
  end

  task automatic send_tick(input logic [PIN_W-1:0] pins);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= pins;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Unused upper data bits are randomized; the block keeps only the low ones.
  task automatic set_cfg(input logic [7:0] scan, input logic [7:0] deb,
                         input logic [15:0] short_t, input logic [15:0] long_t,
                         input logic pl);
    write_reg(REG_SCAN, {8'($urandom), scan});
    write_reg(REG_DEBOUNCE, {8'($urandom), deb});
    write_reg(REG_SHORT, short_t);
    write_reg(REG_LONG, long_t);
    write_reg(REG_PRESSED, {15'($urandom), pl});
  endtask

  // Wait for every expected beat, then let a silent key walk finish.
  task automatic drain_events();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (awaited == 0);
    repeat (40) @(negedge clk);
  endtask

  // Each key holds a level for a random run, then toggles; occasional glitch ticks.
  task automatic run_phase(input int ticks, input int min_run, input int max_run,
                           input int noise_div);
    logic [PIN_W-1:0] pins;
    for (int k = 0; k < PIN_W; k++)
      lane_run[k] = $urandom_range(1, (max_run > 60) ? 30 : max_run);
    for (int t = 0; t < ticks; t++) begin
      for (int k = 0; k < PIN_W; k++) begin
        if (lane_run[k] == 0) begin
          lane_level[k] = ~lane_level[k];
          lane_run[k]   = $urandom_range(min_run, max_run);
        end
        lane_run[k]--;
      end
      pins = lane_level;
      if ($urandom_range(1, noise_div) == 1)
        pins ^= PIN_W'($urandom);
      send_tick(pins);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults
    run_phase(25, 1, 12, 8);
    drain_events();

    // press, glitch, long, release, then a short press on key 0
    set_cfg(8'd10, 8'd20, 16'd30, 16'd60, 1'b0);
    send_tick(6'h3F);
    send_tick(6'h00);
    send_tick(6'h00);
    send_tick(6'h3F);
    send_tick(6'h00);
    send_tick(6'h00);
    send_tick(6'h00);
    send_tick(6'h00);
    send_tick(6'h3F);
    send_tick(6'h3F);
    send_tick(6'h3E);
    send_tick(6'h3E);
    send_tick(6'h3E);
    send_tick(6'h3F);
    send_tick(6'h3F);
    drain_events();

    // pressed level flipped with stable levels kept; zero debounce; short above long;
    // long already reached by the first hold step
    set_cfg(8'd255, 8'd0, 16'd20, 16'd10, 1'b1);
    send_tick(6'h2A);
    send_tick(6'h15);
    send_tick(6'h3F);
    drain_events();

    // debounce count saturates at 255
    set_cfg(8'd200, 8'd255, 16'd0, 16'hFFFF, 1'b0);
    send_tick(6'h00);
    send_tick(6'h00);
    drain_events();

    // zero scan interval: counter stays 0, which meets a zero debounce time
    set_cfg(8'd0, 8'd0, 16'd0, 16'd0, 1'b1);
    send_tick(6'h00);
    send_tick(6'h3F);
    drain_events();

    // unknown register indexes are ignored; zero scan never reaches debounce
    write_reg(REG_PRESSED + 3'($urandom_range(1, 3)), 16'($urandom));
    write_reg(REG_PRESSED + 3'($urandom_range(1, 3)), 16'($urandom));
    write_reg(REG_DEBOUNCE, 16'd5);
    send_tick(6'h15);
    drain_events();

    set_cfg(8'd7, 8'd20, 16'd20, 16'd70, 1'b0);
    run_phase(30, 1, 16, 6);
    drain_events();

    // long holds with a large scan step: debounce count saturates at 255,
    // long events fire after many ticks
    set_cfg(8'd254, 8'd255, 16'd0, 16'd20000, 1'b1);
    lane_level = '0;
    run_phase(100, 60, 90, 100);
    drain_events();

    set_cfg(8'd1, 8'd0, 16'hFFFF, 16'd3, 1'b0);
    run_phase(25, 1, 8, 5);
    drain_events();

    set_cfg(8'd50, 8'd0, 16'd0, 16'd40, 1'b1);
    run_phase(20, 1, 6, 5);
    drain_events();

    set_cfg(8'd0, 8'd0, 16'd0, 16'd0, 1'b0);
    run_phase(10, 1, 4, 4);
    drain_events();

    calm <= 1'b1;
    set_cfg(8'd13, 8'd40, 16'd100, 16'd300, 1'b0);
    run_phase(30, 1, 30, 10);
    drain_events();

    if (fail_count == 0 && awaited == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
